FILE: src/coe_pkg.sv
// Shared types and constants for the clock offset estimator.
package coe_pkg;

  localparam int DW    = 32;
  localparam int RW    = 14;
  localparam int IN_W  = 144;
  localparam int OUT_W = 120;

  localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_START,
    S_DIV,
    S_PEER,
    S_CMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_take;
    logic peer;
    logic compare;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic echo_nz;
    logic cnt_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: src/clock_offset_estimator_top.sv
// Top level of the round-trip clock offset estimator.
//
// The input channel takes one sync request per handshake; the result channel
// returns exactly one result for each request, in order. There is no
// configuration port.
// A request without an echoed tick goes from idle straight to the emit state,
// which loads the result register once it is free and then raises in_tready.
// A request with an echo updates the latency sum and count, then runs a
// serial restoring divider for the mean latency, one quotient bit per clock,
// unless the count has wrapped to zero; it then computes the peer offset,
// compares its error with the least error so far and emits the result.
// One request is worked on at a time, and in_tready is high only
// while the block is idle.
// Results go to an output register, so a new request is taken while an
// earlier result still waits; when the receiver stalls and that register is
// full, the next result waits inside the block and input stays blocked.
// A synchronous active-low reset clears the latency sum and count, sets the
// least error and cached mean to all ones, clears the kept offset and drops
// out_tvalid.
module clock_offset_estimator_top
  import coe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // now_tick, peer_send_tick, echoed_tick, peer_sign, peer_offset, rounds_left
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // offset_sign, offset_value, avg_latency, best_sign, best_offset,
  // send_reply, reply_rounds, finished
  output logic [OUT_W-1:0] out_tdata
);

  cmd_t    cmd;
  status_t status;

  coe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  coe_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: src/coe_div.sv
// Restoring serial divider that produces one quotient bit per cycle.
module coe_div
  import coe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r[DW-1:0], quo_r[DW-1]};
  assign fits    = (shifted >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (shifted - {1'b0, dsr_r}) : shifted;
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/coe_dp.sv
// Datapath: request registers, latency state, offset math and result register.
module coe_dp
  import coe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic [DW-1:0] now_r, psend_r, poff_r, half_r;
  logic          psign_r;
  logic [RW-1:0] rounds_r;
  logic [DW-1:0] sum_r, cnt_r, avg_r, least_r, kept_off_r;
  logic          kept_sign_r;
  logic          osign_r;
  logic [DW-1:0] oval_r, implied_r;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [DW-1:0] in_now, in_echo, in_psend, in_poff;
  logic [DW-1:0] cnt_inc, peer_now, err, quotient;
  logic [RW-1:0] reply;
  logic          send, fin, div_done;

  assign in_now   = in_tdata[31:0];
  assign in_psend = in_tdata[63:32];
  assign in_echo  = in_tdata[95:64];
  assign in_poff  = in_tdata[128:97];

  coe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign cnt_inc  = cnt_r + 1'b1;
  assign peer_now = psend_r - avg_r;
  assign err      = (implied_r > now_r) ? (implied_r - now_r) : (now_r - implied_r);

  assign reply = (rounds_r == '0) ? '0 : (rounds_r - 1'b1);
  assign send  = (reply != '0);
  assign fin   = (rounds_r == '0) || (reply < RW'(2));

  assign status.echo_nz  = (in_echo != '0);
  assign status.cnt_zero = (cnt_r == '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      avg_r       <= ALL_ONES;
      least_r     <= ALL_ONES;
      kept_sign_r <= 1'b0;
      kept_off_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        sum_r <= sum_r + half_r;
        cnt_r <= cnt_inc;
        if (cnt_inc == '0) begin
          avg_r <= ALL_ONES;
        end
      end
      if (cmd.div_take) begin
        avg_r <= quotient;
      end
      if (cmd.compare && (poff_r != '0) && (err < least_r)) begin
        least_r     <= err;
        kept_sign_r <= osign_r;
        kept_off_r  <= oval_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.capture) begin
      now_r    <= in_now;
      psend_r  <= in_psend;
      psign_r  <= in_tdata[96];
      poff_r   <= in_poff;
      rounds_r <= in_tdata[142:129];
      half_r   <= (in_now - in_echo) >> 1;
      osign_r  <= 1'b1;
      oval_r   <= '0;
    end
    if (cmd.peer) begin
      osign_r   <= (now_r > peer_now);
      oval_r    <= (now_r > peer_now) ? (now_r - peer_now) : (peer_now - now_r);
      implied_r <= psign_r ? (peer_now - poff_r) : (peer_now + poff_r);
    end
    if (cmd.emit) begin
      out_data_r <= {6'd0, fin, reply, send, kept_off_r, kept_sign_r, avg_r, oval_r,
                     osign_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/coe_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module coe_ctrl
  import coe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = status.echo_nz ? S_UPD : S_EMIT;
      S_UPD:   state_nxt = S_START;
      S_START: state_nxt = status.cnt_zero ? S_PEER : S_DIV;
      S_DIV:   if (status.div_done) state_nxt = S_PEER;
      S_PEER:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_EMIT;
      S_EMIT:  if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.capture = accept;
      S_UPD:   cmd.update = 1'b1;
      S_START: cmd.div_start = !status.cnt_zero;
      S_DIV:   cmd.div_take = status.div_done;
      S_PEER:  cmd.peer = 1'b1;
      S_CMP:   cmd.compare = 1'b1;
      S_EMIT:  cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result loaded while output register still full");

  a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !status.echo_nz) |=> (state_r == S_EMIT))
    else $error("request without echo did not go straight to output");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_done) |=> (state_r == S_PEER))
    else $error("divider completion not followed by offset step");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule
